FILE: rtl/cld_pkg.sv
// shared types, constants and the header prefix table for the content-length deframer
package cld_pkg;

    localparam int CLD_LEN_WIDTH  = 32;
    localparam int CLD_PREFIX_LEN = 16;

    localparam logic [7:0] CH_LF = 8'h0a;
    localparam logic [7:0] CH_CR = 8'h0d;
    localparam logic [7:0] CH_SP = 8'h20;
    localparam logic [7:0] CH_HT = 8'h09;
    localparam logic [7:0] CH_VT = 8'h0b;
    localparam logic [7:0] CH_FF = 8'h0c;
    localparam logic [7:0] CH_D0 = 8'h30;
    localparam logic [7:0] CH_D9 = 8'h39;

    typedef enum logic [1:0] {
        PH_HUNT   = 2'd0,
        PH_LENGTH = 2'd1,
        PH_HEADER = 2'd2,
        PH_BODY   = 2'd3
    } t_phase;

    // "Content-Length: " one character per index
    function automatic logic [7:0] prefix_char(input logic [3:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0:  c = 8'h43;
            4'd1:  c = 8'h6f;
            4'd2:  c = 8'h6e;
            4'd3:  c = 8'h74;
            4'd4:  c = 8'h65;
            4'd5:  c = 8'h6e;
            4'd6:  c = 8'h74;
            4'd7:  c = 8'h2d;
            4'd8:  c = 8'h4c;
            4'd9:  c = 8'h65;
            4'd10: c = 8'h6e;
            4'd11: c = 8'h67;
            4'd12: c = 8'h74;
            4'd13: c = 8'h68;
            4'd14: c = 8'h3a;
            4'd15: c = 8'h20;
        endcase
        return c;
    endfunction

    function automatic logic is_ws(input logic [7:0] b);
        return (b == CH_SP) || (b == CH_HT) || (b == CH_LF) ||
               (b == CH_VT) || (b == CH_FF) || (b == CH_CR);
    endfunction

endpackage

FILE: rtl/content_length_deframer.sv
// content-length deframer: pulls message bodies out of a framed byte stream
// One byte is taken per clock cycle while the sink does not stall: each byte updates the header
// parser state in the same cycle it is accepted, and a body byte lands in a single
// output register. Input stall follows output stall combinationally, so the block
// holds off the source only while a body byte sits in the output register and the
// sink is stalling; a byte can be accepted in the same cycle the held one leaves.
// Header bytes that produce no body byte are taken at the same rate as any other.
module content_length_deframer #(
    parameter int LEN_WIDTH = cld_pkg::CLD_LEN_WIDTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_body_byte,
    output logic       o_is_last
);
    import cld_pkg::*;

    t_phase                 r_phase, n_phase;
    logic [3:0]             r_match, n_match;
    logic [LEN_WIDTH-1:0]   r_len, n_len;
    logic                   r_dig_end, n_dig_end;
    logic                   r_fld_start, n_fld_start;
    logic                   r_nl_seen, n_nl_seen;
    logic [LEN_WIDTH-1:0]   r_count, n_count;
    logic                   r_out_valid;
    logic [7:0]             r_out_byte;
    logic                   r_out_last;

    logic                   in_xfer;
    logic                   emit;
    logic                   emit_last;
    logic                   ws;
    logic                   is_digit;
    logic                   prefix_hit;
    logic [LEN_WIDTH+3:0]   acc;
    logic [LEN_WIDTH-1:0]   count_inc;

    assign o_stall = r_out_valid && i_stall;
    assign in_xfer = i_valid && !o_stall;

    assign ws         = is_ws(i_data_byte);
    assign is_digit   = (i_data_byte >= CH_D0) && (i_data_byte <= CH_D9);
    assign prefix_hit = (i_data_byte == prefix_char(r_match));
    // len * 10 + digit, four spare bits catch overflow
    assign acc = ({4'b0, r_len} << 3) + ({4'b0, r_len} << 1)
               + {{LEN_WIDTH{1'b0}}, i_data_byte[3:0]};
    assign count_inc = r_count + {{(LEN_WIDTH-1){1'b0}}, 1'b1};

    // next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_HUNT: begin
                if (prefix_hit && (r_match == 4'(CLD_PREFIX_LEN - 1))) begin
                    n_phase = PH_LENGTH;
                end
            end
            PH_LENGTH: begin
                if (ws && r_fld_start) begin
                    n_phase = PH_HEADER;
                end else if (!r_fld_start && ws) begin
                    n_phase = PH_LENGTH;
                end else if (ws) begin
                    n_phase = PH_HEADER;
                end
            end
            PH_HEADER: begin
                if (i_data_byte == CH_LF && r_nl_seen) begin
                    n_phase = PH_BODY;
                end
            end
            PH_BODY: begin
                if (emit_last) begin
                    n_phase = PH_HUNT;
                end
            end
        endcase
    end

    // result decisions
    always_comb begin
        emit      = 1'b0;
        emit_last = 1'b0;
        unique case (r_phase)
            PH_BODY: begin
                emit      = !((r_count == '0) && ws);
                emit_last = emit && (count_inc >= r_len);
            end
            PH_HUNT, PH_LENGTH, PH_HEADER: begin
                emit      = 1'b0;
                emit_last = 1'b0;
            end
        endcase
    end

    // parser datapath
    always_comb begin
        n_match     = r_match;
        n_len       = r_len;
        n_dig_end   = r_dig_end;
        n_fld_start = r_fld_start;
        n_nl_seen   = r_nl_seen;
        n_count     = r_count;
        unique case (r_phase)
            PH_HUNT: begin
                n_match = prefix_hit ? r_match + 4'd1 : 4'd0;
                if (prefix_hit && (r_match == 4'(CLD_PREFIX_LEN - 1))) begin
                    n_len       = '0;
                    n_dig_end   = 1'b0;
                    n_fld_start = 1'b0;
                end
            end
            PH_LENGTH: begin
                if (r_fld_start || !ws) begin
                    n_fld_start = 1'b1;
                    if (ws) begin
                        // a newline closing the field counts toward the header end
                        n_nl_seen = (i_data_byte == CH_LF);
                    end else if (!r_dig_end) begin
                        if (is_digit) begin
                            n_len = (acc[LEN_WIDTH+3:LEN_WIDTH] != 4'd0)
                                  ? '1 : acc[LEN_WIDTH-1:0];
                        end else begin
                            n_dig_end = 1'b1;
                        end
                    end
                end
            end
            PH_HEADER: begin
                if (i_data_byte == CH_LF) begin
                    n_nl_seen = !r_nl_seen;
                    if (r_nl_seen) begin
                        n_count = '0;
                    end
                end else if (i_data_byte != CH_CR) begin
                    n_nl_seen = 1'b0;
                end
            end
            PH_BODY: begin
                if (emit) begin
                    n_count = count_inc;
                end
                if (emit_last) begin
                    n_match     = 4'd0;
                    n_len       = '0;
                    n_dig_end   = 1'b0;
                    n_fld_start = 1'b0;
                    n_nl_seen   = 1'b0;
                    n_count     = '0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_match     <= 4'd0;
            r_len       <= '0;
            r_dig_end   <= 1'b0;
            r_fld_start <= 1'b0;
            r_nl_seen   <= 1'b0;
            r_count     <= '0;
        end else if (in_xfer) begin
            r_phase     <= n_phase;
            r_match     <= n_match;
            r_len       <= n_len;
            r_dig_end   <= n_dig_end;
            r_fld_start <= n_fld_start;
            r_nl_seen   <= n_nl_seen;
            r_count     <= n_count;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= emit;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && emit) begin
            r_out_byte <= i_data_byte;
            r_out_last <= emit_last;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_body_byte = r_out_byte;
    assign o_is_last   = r_out_last;

endmodule

FILE: rtl/cld_checker.sv
// port-level checks for the content-length deframer, bound to the top level
module cld_port_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_body_byte,
    input logic       o_is_last
);

    // a held body byte stays put while the sink stalls
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_body_byte) && $stable(o_is_last)))
        else $error("output transfer changed while stalled");

    // source is held off only while a byte waits on a stalled sink
    a_stall_cause: assert property (@(posedge i_clk)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a pending output");

    // every new body byte comes from an input transfer
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !$past(o_valid && i_stall)) |-> $past(i_valid && !o_stall))
        else $error("output appeared without an input transfer");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

endmodule

bind content_length_deframer cld_port_checker u_cld_checker (.*);

FILE: tb/sv/cld_checker.sv
// transfer monitor, deframing predictor and result checker for the content-length deframer
module cld_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [7:0] i_in_data,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [7:0] i_out_body,
    input  logic       i_out_last,
    output int         o_fail_count,
    output int         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import cld_pkg::*;

    localparam int LEN_W = CLD_LEN_WIDTH;
    localparam logic [63:0] LEN_SAT = (64'd1 << LEN_W) - 64'd1;
    localparam logic [8*CLD_PREFIX_LEN-1:0] HDR_TAG = "Content-Length: ";

    typedef struct packed {
        logic [7:0] body;
        logic       last;
    } t_body_beat;

    t_body_beat body_exp_q[$];

    t_phase           hunt_phase;
    logic [4:0]       tag_pos;
    logic [LEN_W-1:0] msg_len;
    logic             digits_done;
    logic             field_seen;
    logic [1:0]       lf_run;
    logic [LEN_W-1:0] sent_cnt;

    function automatic bit blank_byte(input logic [7:0] b);
        return b == 8'h20 || b == 8'h09 || b == 8'h0a || b == 8'h0b ||
               b == 8'h0c || b == 8'h0d;
    endfunction

    task automatic clear_frame();
        hunt_phase  = PH_HUNT;
        tag_pos     = '0;
        msg_len     = '0;
        digits_done = 1'b0;
        field_seen  = 1'b0;
        lf_run      = '0;
        sent_cnt    = '0;
    endtask

    // advances the deframing state by one byte, pushes a body beat if one comes out
    task automatic deframe_step(input logic [7:0] b);
        logic [63:0] digit;
        t_body_beat  beat;
        unique case (hunt_phase)
            PH_HUNT: begin
                if (b == HDR_TAG[8*(CLD_PREFIX_LEN-1-int'(tag_pos)) +: 8]) begin
                    tag_pos = tag_pos + 5'd1;
                end else begin
                    tag_pos = '0;
                end
                if (tag_pos >= CLD_PREFIX_LEN) begin
                    tag_pos     = '0;
                    hunt_phase  = PH_LENGTH;
                    msg_len     = '0;
                    digits_done = 1'b0;
                    field_seen  = 1'b0;
                end
            end
            PH_LENGTH: begin
                if (field_seen || !blank_byte(b)) begin
                    field_seen = 1'b1;
                    if (blank_byte(b)) begin
                        hunt_phase = PH_HEADER;
                        lf_run     = (b == CH_LF) ? 2'd1 : 2'd0;
                    end else if (!digits_done) begin
                        if (b >= CH_D0 && b <= CH_D9) begin
                            digit = 64'(b - CH_D0);
                            if (64'(msg_len) > (LEN_SAT - digit) / 64'd10) begin
                                msg_len = LEN_SAT[LEN_W-1:0];
                            end else begin
                                msg_len = LEN_W'(64'(msg_len) * 64'd10 + digit);
                            end
                        end else begin
                            digits_done = 1'b1;
                        end
                    end
                end
            end
            PH_HEADER: begin
                if (b == CH_LF) begin
                    lf_run = lf_run + 2'd1;
                end else if (b != CH_CR) begin
                    lf_run = '0;
                end
                if (lf_run >= 2'd2) begin
                    lf_run     = '0;
                    hunt_phase = PH_BODY;
                    sent_cnt   = '0;
                end
            end
            default: begin
                if (sent_cnt != '0 || !blank_byte(b)) begin
                    sent_cnt  = sent_cnt + 1'b1;
                    beat.body = b;
                    beat.last = (sent_cnt >= msg_len);
                    body_exp_q.push_back(beat);
                    if (beat.last) begin
                        clear_frame();
                    end
                end
            end
        endcase
    endtask

    initial begin
        o_fail_count = 0;
        clear_frame();
    end

    always @(posedge i_clk) begin
        t_body_beat want;
        if (!i_rst_n) begin
            clear_frame();
            body_exp_q.delete();
        end else begin
            // the result leaving now belongs to an older byte, so check before predicting
            if (i_out_valid && !i_out_stall) begin
                if (body_exp_q.size() == 0) begin
                    $error("unexpected body transfer: body_byte %h is_last %b",
                           i_out_body, i_out_last);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = body_exp_q.pop_front();
                    if (i_out_body !== want.body) begin
                        $error("body_byte: expected %h, actual %h", want.body, i_out_body);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_out_last !== want.last) begin
                        $error("is_last: expected %b, actual %b", want.last, i_out_last);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                deframe_step(i_in_data);
            end
        end
        o_pending = body_exp_q.size();
    end

endmodule

FILE: tb/sv/tb_top.sv
// stimulus, clocking and verdict for the content-length deframer testbench
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import cld_pkg::*;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [7:0] i_data_byte;
    logic       o_valid;
    logic       i_stall;
    logic [7:0] o_body_byte;
    logic       o_is_last;
    int         fail_count;
    int         pending;

    logic [7:0] byte_stream_q[$];

    content_length_deframer DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data_byte (i_data_byte),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_body_byte (o_body_byte),
        .o_is_last   (o_is_last)
    );

    cld_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_in_data    (i_data_byte),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_out_body   (o_body_byte),
        .i_out_last   (o_is_last),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    function automatic logic [7:0] pick_blank();
        logic [7:0] pool [6];
        pool = '{CH_SP, CH_HT, CH_LF, CH_VT, CH_FF, CH_CR};
        return pool[$urandom_range(0, 5)];
    endfunction

    function automatic bit is_blank(input logic [7:0] b);
        return b == CH_SP || b == CH_HT || b == CH_LF || b == CH_VT ||
               b == CH_FF || b == CH_CR;
    endfunction

    task automatic push_byte(input logic [7:0] b);
        byte_stream_q.push_back(b);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            byte_stream_q.push_back(s[i]);
        end
    endtask

    task automatic push_nl(input bit crlf);
        if (crlf) begin
            push_byte(CH_CR);
        end
        push_byte(CH_LF);
    endtask

    // one well-formed frame with random spacing, header lines and body content
    task automatic push_frame(input int unsigned body_len);
        bit          crlf;
        int unsigned term;
        logic [7:0]  c;
        crlf = $urandom_range(0, 1);
        push_text("Content-Length: ");
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) push_byte(pick_blank());
        end
        if (body_len == 0 && $urandom_range(0, 3) == 0) begin
            // field with no digits at all
            push_text("n/a");
        end else begin
            if ($urandom_range(0, 4) == 0) begin
                push_text("00");
            end
            push_text($sformatf("%0d", body_len));
            if ($urandom_range(0, 7) == 0) begin
                // junk stops the count, the digits after it are ignored
                do c = 8'($urandom_range(0, 255));
                while (is_blank(c) || (c >= CH_D0 && c <= CH_D9));
                push_byte(c);
                push_text($sformatf("%0d", $urandom_range(0, 99)));
            end
        end
        term = $urandom_range(0, 3);
        case (term)
            0: push_byte(CH_SP);
            1: push_byte(CH_HT);
            2: push_byte(CH_CR);
            default: push_byte(CH_LF);
        endcase
        if (term != 3) begin
            push_nl(crlf);
        end
        repeat ($urandom_range(0, 2)) begin
            repeat ($urandom_range(1, 6)) begin
                do c = 8'($urandom_range(0, 255));
                while (c == CH_LF || c == CH_CR);
                push_byte(c);
            end
            push_nl(crlf);
        end
        push_nl(crlf);
        repeat ($urandom_range(0, 2)) push_byte(pick_blank());
        do c = 8'($urandom_range(0, 255));
        while (is_blank(c));
        push_byte(c);
        for (int unsigned k = 1; k < body_len; k++) begin
            push_byte(8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    // sink side back-pressure
    initial begin
        int unsigned run;
        i_stall = 1'b0;
        wait (i_rst_n == 1'b1);
        @(posedge i_clk);
        forever begin
            case ($urandom_range(0, 9))
                0: begin
                    i_stall <= 1'b0;
                    run = $urandom_range(20, 60);
                end
                1: begin
                    i_stall <= 1'b1;
                    run = $urandom_range(8, 30);
                end
                default: begin
                    i_stall <= 1'($urandom_range(0, 1));
                    run = $urandom_range(1, 3);
                end
            endcase
            repeat (run) @(posedge i_clk);
        end
    end

    initial begin
        int unsigned idx;
        int unsigned gap;
        int unsigned calm_left;
        int unsigned sel;
        int          wait_cnt;
        string       tag_text;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_data_byte = 8'h00;
        tag_text    = "Content-Length: ";

        // directed frames
        push_text("Content-Length: 5");
        push_nl(1'b1);
        push_nl(1'b1);
        push_text("hello");
        push_text("Content-Length: 0");
        push_nl(1'b1);
        push_nl(1'b1);
        push_text(" \tZ");
        push_text("Content-Length: 3\n\nabc");
        push_text("Content-Length: 2x9 ");
        push_nl(1'b1);
        push_nl(1'b1);
        push_text("ab");
        push_text("Content-Length: zz\t\n\nQ");
        push_text("Content-Length:  \t4");
        push_nl(1'b1);
        push_text("X: y");
        push_nl(1'b1);
        push_nl(1'b1);
        push_byte(8'h00);
        push_byte(8'hff);
        push_byte(8'h80);
        push_byte(8'h7f);
        // a repeated first letter breaks the match and is not retried
        push_text("CContent-Length: 1\n\nA");
        push_text("Content-Length: 0003\n");
        push_byte(CH_CR);
        push_byte(CH_CR);
        push_text("\nxyz");

        // random frames mixed with noise and broken prefixes
        while (byte_stream_q.size() < 680) begin
            sel = $urandom_range(0, 9);
            if (sel == 0) begin
                repeat ($urandom_range(1, 8)) push_byte(8'($urandom_range(0, 255)));
            end else if (sel == 1) begin
                push_text(tag_text.substr(0, $urandom_range(0, CLD_PREFIX_LEN - 2)));
                push_byte(8'($urandom_range(0, 255)));
            end else if ($urandom_range(0, 9) == 0) begin
                push_frame($urandom_range(30, 70));
            end else begin
                push_frame($urandom_range(0, 12));
            end
        end
        // saturating length last, since that body never ends
        push_text("Content-Length: 99999999999");
        push_nl(1'b1);
        push_nl(1'b1);
        repeat (20) push_byte(8'($urandom_range(0, 255)));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        calm_left = 0;
        for (idx = 0; idx < byte_stream_q.size(); idx++) begin
            if (calm_left > 0) begin
                calm_left--;
                gap = 0;
            end else if ($urandom_range(0, 49) == 0) begin
                calm_left = $urandom_range(20, 60);
                gap = 0;
            end else if ($urandom_range(0, 9) < 6) begin
                gap = 0;
            end else if ($urandom_range(0, 9) < 8) begin
                gap = $urandom_range(1, 3);
            end else begin
                gap = $urandom_range(8, 30);
            end
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_valid     <= 1'b1;
            i_data_byte <= byte_stream_q[idx];
            do @(posedge i_clk);
            while (o_stall);
        end
        i_valid <= 1'b0;

        // sample the checker away from the active edge
        wait_cnt = 0;
        @(negedge i_clk);
        while (pending != 0 && wait_cnt < 5000) begin
            @(negedge i_clk);
            wait_cnt++;
        end
        if (pending != 0) begin
            $display("tb: failure");
        end else begin
            repeat (10) @(negedge i_clk);
            if (fail_count == 0 && pending == 0) begin
                $display("tb: success");
            end else begin
                $display("tb: failure");
            end
        end
        $finish;
    end

endmodule
